/* hw/rtl/etbd_pkg.sv */
package etbd_pkg;

    localparam int SINCOS_TABLE_DEPTH_DEF = 1024;
    localparam int MAP_STRIDE_DEF = 4;
    localparam logic [15:0] THRESHOLD_RESET = 16'h8000;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
    localparam longint RAD_TO_DEG_Q16 = 64'sd3754937;

    // Width of the geometry sums, in units of 2^-21 pixel.
    localparam int GEO_W = 40;
    localparam int FRAC_SHIFT = 21;

    typedef struct packed {
        logic [9:0]         cell_col;
        logic [9:0]         cell_row;
        logic [15:0]        score;
        logic [15:0]        dist_top;
        logic [15:0]        dist_right;
        logic [15:0]        dist_bottom;
        logic [15:0]        dist_left;
        logic signed [15:0] rot_angle;
    } cell_t;

    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic signed [15:0] angle_degrees;
        logic [15:0]        box_score;
    } box_t;

    // Sine and cosine in Q1.14 of an angle in Q30 radians, 0 to 2*pi, packed {sin, cos}.
    // The quadrant is folded out and a truncated Taylor series covers the remainder.
    // It is evaluated only at elaboration, to fill the constant table.
    function automatic logic [31:0] sincos_entry(input longint theta);
        longint q;
        longint r;
        longint ss;
        longint cs;
        longint so;
        longint co;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        q = 0;
        if (theta >= 3 * HALF_PI_Q30)
        begin
            q = 3;
        end
        else if (theta >= 2 * HALF_PI_Q30)
        begin
            q = 2;
        end
        else if (theta >= HALF_PI_Q30)
        begin
            q = 1;
        end
        r = theta - q * HALF_PI_Q30;
        x2 = (longint'(r) * longint'(r)) >> 30;
        ts = longint'(r);
        tc = 64'd1 << 30;
        ss = r;
        cs = 64'sd1 << 30;
        // Each term is the previous one times x^2 over the next two factorial factors.
        ts = ((ts * x2) >> 30) / 64'd6;
        tc = ((tc * x2) >> 30) / 64'd2;
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd20;
        tc = ((tc * x2) >> 30) / 64'd12;
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd42;
        tc = ((tc * x2) >> 30) / 64'd30;
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd72;
        tc = ((tc * x2) >> 30) / 64'd56;
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd110;
        tc = ((tc * x2) >> 30) / 64'd90;
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd156;
        tc = ((tc * x2) >> 30) / 64'd132;
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
        ts = ((ts * x2) >> 30) / 64'd210;
        tc = ((tc * x2) >> 30) / 64'd182;
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
        case (q)
            0:       begin so = ss;  co = cs;  end
            1:       begin so = cs;  co = -ss; end
            2:       begin so = -ss; co = -cs; end
            default: begin so = -cs; co = ss;  end
        endcase
        so = (so + 64'sd32768) >>> 16;
        co = (co + 64'sd32768) >>> 16;
        return {so[15:0], co[15:0]};
    endfunction

    function automatic logic signed [15:0] sat_s16(input logic signed [GEO_W-1:0] v);
        if (v < -(GEO_W'(32768)))
        begin
            return 16'sh8000;
        end
        else if (v > GEO_W'(32767))
        begin
            return 16'sh7fff;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [GEO_W-1:0] v);
        if (v < 0)
        begin
            return 16'h0000;
        end
        else if (v > GEO_W'(65535))
        begin
            return 16'hffff;
        end
        return v[15:0];
    endfunction

endpackage

/* hw/rtl/etbd_sincos_rom.sv */
module etbd_sincos_rom #(
    parameter int Depth = etbd_pkg::SINCOS_TABLE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [$clog2(Depth)-1:0] idx,
    output logic signed [15:0]       sin_q,
    output logic signed [15:0]       cos_q
);
    import etbd_pkg::*;

    // Entry k holds {sin, cos} at 2*pi*k/Depth; the contents are fixed at elaboration.
    logic [31:0] rom [Depth];

    for (genvar k = 0; k < Depth; k++)
    begin : g_entry
        localparam longint Theta = (longint'(k) * TWO_PI_Q30 + longint'(Depth / 2))
                                   / longint'(Depth);
        localparam logic [31:0] Entry = sincos_entry(Theta);
        assign rom[k] = Entry;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_q <= rom[idx][31:16];
            cos_q <= rom[idx][15:0];
        end
    end

endmodule

/* hw/rtl/east_text_box_decoder.sv */
// Decodes one score-map cell per clock into an axis-aligned text box. Cells whose score is
// below the threshold register are dropped; the rest pass through a six-stage pipeline
// (input, index multiply, sine/cosine table read, eight products, bound sums, rounding and
// saturation). A new cell is taken every cycle while the output side keeps up; a stall at
// the output stops the full stages that have no empty stage after them, and the input stall
// rises once the first stage is full and cannot move. The sine/cosine table is a ROM
// of SINCOS_TABLE_DEPTH entries built at elaboration, so no fill time follows reset.
module east_text_box_decoder #(
    parameter int SINCOS_TABLE_DEPTH = etbd_pkg::SINCOS_TABLE_DEPTH_DEF,
    parameter int MAP_STRIDE = etbd_pkg::MAP_STRIDE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cell_valid,
    output logic           cell_stall,
    input  etbd_pkg::cell_t map_cell,
    output logic           box_valid,
    input  logic           box_stall,
    output etbd_pkg::box_t box,
    input  logic           threshold_we,
    input  logic [15:0]    threshold_data
);
    import etbd_pkg::*;

    localparam int IW = $clog2(SINCOS_TABLE_DEPTH);
    localparam longint IdxMul = longint'(SINCOS_TABLE_DEPTH) * INV_TWO_PI_Q32;

    logic [15:0] thr_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic        rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    logic        keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (threshold_we)
        begin
            thr_reg <= threshold_data;
        end
    end

    assign rdy6 = !v6_reg || !box_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign cell_stall = !rdy1;
    assign keep = cell_valid && (map_cell.score >= thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= keep;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: input register.
    cell_t s1_reg;
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= map_cell;
        end
    end

    // Stage 2: table index product, degree product, box height and width.
    logic signed [60:0] idx_prod_reg;
    logic signed [GEO_W-1:0] deg_prod_reg;
    logic [16:0] h2_reg, w2_reg;
    cell_t s2_reg;
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            idx_prod_reg <= 61'(s1_reg.rot_angle) * 61'(IdxMul) + (61'sd1 <<< 44);
            deg_prod_reg <= -(GEO_W'(s1_reg.rot_angle)) * GEO_W'(RAD_TO_DEG_Q16);
            h2_reg <= 17'(s1_reg.dist_top) + 17'(s1_reg.dist_bottom);
            w2_reg <= 17'(s1_reg.dist_right) + 17'(s1_reg.dist_left);
            s2_reg <= s1_reg;
        end
    end

    // Stage 3: the rounded index wraps once into the table; the ROM output is registered.
    logic signed [15:0] idx_raw;
    logic signed [16:0] idx_wrap;
    logic [IW-1:0]      idx;
    logic signed [GEO_W-1:0] deg_round;
    logic signed [15:0] s3_sin, s3_cos;
    logic signed [15:0] deg3_reg;
    logic [16:0] h3_reg, w3_reg;
    cell_t s3_reg;

    assign idx_raw = idx_prod_reg[60:45];
    assign idx_wrap = (idx_raw < 0) ? (17'(idx_raw) + 17'(SINCOS_TABLE_DEPTH)) : 17'(idx_raw);
    assign idx = idx_wrap[IW-1:0];
    assign deg_round = (deg_prod_reg + (GEO_W'(1) <<< 22)) >>> 23;

    etbd_sincos_rom #(
        .Depth (SINCOS_TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .en    (rdy3),
        .idx   (idx),
        .sin_q (s3_sin),
        .cos_q (s3_cos)
    );

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            deg3_reg <= sat_s16(deg_round);
            h3_reg <= h2_reg;
            w3_reg <= w2_reg;
            s3_reg <= s2_reg;
        end
    end

    // Stage 4: the eight rotation products, the scaled cell origin and the scaled box extents.
    logic signed [33:0] cdr_reg, sdb_reg, sdr_reg, cdb_reg, sh_reg, cw_reg, ch_reg, sw_reg;
    logic signed [GEO_W-1:0] bx_reg, by_reg, hw_reg, hh_reg;
    logic signed [15:0] deg4_reg;
    logic [15:0] score4_reg;
    logic signed [17:0] dr_s, db_s, h_s, w_s;

    assign dr_s = 18'(s3_reg.dist_right);
    assign db_s = 18'(s3_reg.dist_bottom);
    assign h_s = 18'(h3_reg);
    assign w_s = 18'(w3_reg);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            cdr_reg <= 34'(s3_cos * dr_s);
            sdb_reg <= 34'(s3_sin * db_s);
            sdr_reg <= 34'(s3_sin * dr_s);
            cdb_reg <= 34'(s3_cos * db_s);
            sh_reg <= 34'(s3_sin * h_s);
            cw_reg <= 34'(s3_cos * w_s);
            ch_reg <= 34'(s3_cos * h_s);
            sw_reg <= 34'(s3_sin * w_s);
            bx_reg <= (GEO_W'(s3_reg.cell_col) * GEO_W'(MAP_STRIDE)) <<< 20;
            by_reg <= (GEO_W'(s3_reg.cell_row) * GEO_W'(MAP_STRIDE)) <<< 20;
            hw_reg <= GEO_W'(w3_reg) <<< 14;
            hh_reg <= GEO_W'(h3_reg) <<< 14;
            deg4_reg <= deg3_reg;
            score4_reg <= s3_reg.score;
        end
    end

    // Stage 5: doubled centre plus and minus the half extents, in 2^-21 pixel.
    logic signed [GEO_W-1:0] ox, oy, cx, cy;
    logic signed [GEO_W-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic signed [15:0] deg5_reg;
    logic [15:0] score5_reg;

    assign ox = bx_reg + GEO_W'(cdr_reg) + GEO_W'(sdb_reg);
    assign oy = by_reg - GEO_W'(sdr_reg) + GEO_W'(cdb_reg);
    assign cx = (ox <<< 1) - GEO_W'(sh_reg) - GEO_W'(cw_reg);
    assign cy = (oy <<< 1) - GEO_W'(ch_reg) + GEO_W'(sw_reg);

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            lo_x_reg <= cx - hw_reg;
            hi_x_reg <= cx + hw_reg;
            lo_y_reg <= cy - hh_reg;
            hi_y_reg <= cy + hh_reg;
            deg5_reg <= deg4_reg;
            score5_reg <= score4_reg;
        end
    end

    // Stage 6: floor and ceil to whole pixels, extents, saturation.
    localparam logic signed [GEO_W-1:0] CeilBias = (GEO_W'(1) <<< FRAC_SHIFT) - GEO_W'(1);
    logic signed [GEO_W-1:0] left_px, right_px, top_px, bottom_px;
    box_t box_next;
    box_t box_reg;

    assign left_px = lo_x_reg >>> FRAC_SHIFT;
    assign right_px = (hi_x_reg + CeilBias) >>> FRAC_SHIFT;
    assign top_px = lo_y_reg >>> FRAC_SHIFT;
    assign bottom_px = (hi_y_reg + CeilBias) >>> FRAC_SHIFT;

    always_comb
    begin
        box_next.box_left = sat_s16(left_px);
        box_next.box_top = sat_s16(top_px);
        box_next.box_width = sat_u16(right_px - left_px + GEO_W'(1));
        box_next.box_height = sat_u16(bottom_px - top_px + GEO_W'(1));
        box_next.angle_degrees = deg5_reg;
        box_next.box_score = score5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy6)
        begin
            box_reg <= box_next;
        end
    end

    assign box_valid = v6_reg;
    assign box = box_reg;

    a_drop_low_score: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_stall && (map_cell.score < thr_reg)) |=> !v1_reg)
        else $error("cell below threshold entered the pipeline");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && v6_reg))
        else $error("input stalled with a free pipeline stage");

    a_box_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid |-> (box.box_width != 16'd0 && box.box_height != 16'd0))
        else $error("box with zero extent");

endmodule

/* tb/tb_east_text_box_decoder.sv */
module tb_east_text_box_decoder;
    import etbd_pkg::*;

    localparam int DEPTH = 1024;
    localparam int STRIDE = 4;
    localparam int DRAIN_CYCLES = 12;

    logic clk;
    logic rst_n;
    logic cell_valid;
    logic cell_stall;
    cell_t map_cell;
    logic box_valid;
    logic box_stall;
    box_t box;
    logic threshold_we;
    logic [15:0] threshold_data;

    east_text_box_decoder uut (
        .clk(clk),
        .rst_n(rst_n),
        .cell_valid(cell_valid),
        .cell_stall(cell_stall),
        .map_cell(map_cell),
        .box_valid(box_valid),
        .box_stall(box_stall),
        .box(box),
        .threshold_we(threshold_we),
        .threshold_data(threshold_data)
    );

    logic signed [15:0] sin_q14 [DEPTH];
    logic signed [15:0] cos_q14 [DEPTH];
    logic [15:0] cur_threshold;
    box_t pending_boxes [$];
    bit quiet_sides;
    int boxes_seen;
    int cells_sent;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("Timed out with %0d boxes outstanding.", pending_boxes.size());
        $display("== FAIL ==");
        $finish;
    end

    // Truncated Taylor series in Q30 over one quadrant, then rounded to Q1.14.
    function automatic void build_trig_tables();
        longint th;
        longint q;
        longint r;
        longint ss;
        longint cs;
        longint so;
        longint co;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        for (int k = 0; k < DEPTH; k++)
        begin
            th = (longint'(k) * TWO_PI_Q30 + DEPTH / 2) / DEPTH;
            q = th / HALF_PI_Q30;
            if (q > 3)
            begin
                q = 3;
            end
            r = th - q * HALF_PI_Q30;
            x2 = unsigned'(r * r) >> 30;
            ts = unsigned'(r);
            tc = 64'd1 << 30;
            ss = r;
            cs = 64'sd1 << 30;
            for (int n = 1; n <= 7; n++)
            begin
                ts = ((ts * x2) >> 30) / unsigned'(64'((2 * n) * (2 * n + 1)));
                tc = ((tc * x2) >> 30) / unsigned'(64'((2 * n - 1) * (2 * n)));
                if (n % 2 == 1)
                begin
                    ss -= longint'(ts);
                    cs -= longint'(tc);
                end
                else
                begin
                    ss += longint'(ts);
                    cs += longint'(tc);
                end
            end
            case (q)
                0:       begin so = ss;  co = cs;  end
                1:       begin so = cs;  co = -ss; end
                2:       begin so = -ss; co = -cs; end
                default: begin so = -cs; co = ss;  end
            endcase
            sin_q14[k] = 16'((so + 64'sd32768) >>> 16);
            cos_q14[k] = 16'((co + 64'sd32768) >>> 16);
        end
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Returns 1 and the expected box when the cell clears the threshold.
    function automatic bit decode_box(input cell_t c, output box_t b);
        longint a;
        longint idx;
        longint s;
        longint co;
        longint h;
        longint w;
        longint ox;
        longint oy;
        longint cx;
        longint cy;
        longint lft;
        longint rgt;
        longint tp;
        longint bot;
        longint deg;
        b = '0;
        if (c.score < cur_threshold)
        begin
            return 1'b0;
        end
        a = longint'(c.rot_angle);
        idx = (a * DEPTH * INV_TWO_PI_Q32 + (64'sd1 <<< 44)) >>> 45;
        idx = idx & (DEPTH - 1);
        s = sin_q14[idx];
        co = cos_q14[idx];
        h = longint'(c.dist_top) + longint'(c.dist_bottom);
        w = longint'(c.dist_right) + longint'(c.dist_left);
        ox = ((longint'(c.cell_col) * STRIDE) <<< 20) + co * c.dist_right + s * c.dist_bottom;
        oy = ((longint'(c.cell_row) * STRIDE) <<< 20) - s * c.dist_right + co * c.dist_bottom;
        cx = (ox - s * h) + (ox - co * w);
        cy = (oy - co * h) + (oy + s * w);
        lft = (cx - (w <<< 14)) >>> 21;
        rgt = -((-(cx + (w <<< 14))) >>> 21);
        tp = (cy - (h <<< 14)) >>> 21;
        bot = -((-(cy + (h <<< 14))) >>> 21);
        deg = (-a * RAD_TO_DEG_Q16 + (64'sd1 <<< 22)) >>> 23;
        b.box_left = 16'(clamp(lft, -32768, 32767));
        b.box_top = 16'(clamp(tp, -32768, 32767));
        b.box_width = 16'(clamp(rgt - lft + 1, 0, 65535));
        b.box_height = 16'(clamp(bot - tp + 1, 0, 65535));
        b.angle_degrees = 16'(clamp(deg, -32768, 32767));
        b.box_score = c.score;
        return 1'b1;
    endfunction

    function automatic bit take_gap();
        return !quiet_sides && ($urandom_range(99) < 9);
    endfunction

    // Output side: random stalls and comparison against the oldest expected box.
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n)
        begin
            if (box_valid && !box_stall)
            begin
                if (pending_boxes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected box %p", box);
                    end
                end
                else
                begin
                    want = pending_boxes.pop_front();
                    boxes_seen++;
                    if (box.box_left !== want.box_left || box.box_top !== want.box_top ||
                        box.box_width !== want.box_width ||
                        box.box_height !== want.box_height ||
                        box.angle_degrees !== want.angle_degrees ||
                        box.box_score !== want.box_score)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Box mismatch: expected %p, got %p", want, box);
                        end
                    end
                end
            end
            box_stall <= take_gap();
        end
        else
        begin
            box_stall <= 1'b0;
        end
    end

    task automatic send_cell(input cell_t c);
        box_t b;
        while (take_gap())
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        map_cell <= c;
        do
        begin
            @(posedge clk);
        end
        while (cell_stall);
        cells_sent++;
        if (decode_box(c, b))
        begin
            pending_boxes.push_back(b);
        end
    endtask

    task automatic wait_drained();
        cell_valid <= 1'b0;
        @(posedge clk);
        while (pending_boxes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [15:0] v);
        wait_drained();
        threshold_we <= 1'b1;
        threshold_data <= v;
        @(posedge clk);
        threshold_we <= 1'b0;
        cur_threshold = v;
    endtask

    function automatic cell_t make_cell(int col, int row, int sc, int dt, int dr, int db,
                                        int dl, int ang);
        cell_t c;
        c.cell_col = 10'(col);
        c.cell_row = 10'(row);
        c.score = 16'(sc);
        c.dist_top = 16'(dt);
        c.dist_right = 16'(dr);
        c.dist_bottom = 16'(db);
        c.dist_left = 16'(dl);
        c.rot_angle = 16'(ang);
        return c;
    endfunction

    // Mostly plausible text boxes; the rest is fully random noise.
    function automatic cell_t random_cell();
        cell_t c;
        c = cell_t'($bits(cell_t)'({$urandom, $urandom, $urandom, $urandom}));
        if ($urandom_range(99) < 75)
        begin
            c.score = 16'(cur_threshold) + 16'($urandom_range(65535 - cur_threshold));
            c.dist_top = 16'($urandom_range(4095));
            c.dist_right = 16'($urandom_range(8191));
            c.dist_bottom = 16'($urandom_range(4095));
            c.dist_left = 16'($urandom_range(8191));
            c.rot_angle = 16'($signed($urandom_range(12868)) - 6434);
        end
        return c;
    endfunction

    task automatic test_directed();
        send_cell(make_cell(0, 0, 32768, 0, 0, 0, 0, 0));
        send_cell(make_cell(1023, 1023, 65535, 65535, 65535, 65535, 65535, 32767));
        send_cell(make_cell(0, 1023, 65535, 65535, 0, 65535, 0, -32768));
        send_cell(make_cell(1023, 0, 65535, 0, 65535, 0, 65535, -32768));
        send_cell(make_cell(5, 7, 32767, 100, 100, 100, 100, 0));
        send_cell(make_cell(10, 20, 40000, 640, 1280, 640, 1280, 6434));
        send_cell(make_cell(10, 20, 40000, 640, 1280, 640, 1280, -6434));
        send_cell(make_cell(300, 200, 50000, 320, 960, 320, 960, 25736));
        send_cell(make_cell(300, 200, 50000, 320, 960, 320, 960, -25736));
        send_cell(make_cell(512, 512, 65535, 1, 1, 1, 1, 12868));
        send_cell(make_cell(0, 0, 65535, 65535, 65535, 65535, 65535, 19302));
        send_cell(make_cell(1023, 1023, 65535, 0, 0, 0, 0, 1));
        send_cell(make_cell(3, 3, 0, 500, 500, 500, 500, 100));
        send_cell(make_cell(100, 100, 60000, 12345, 54321, 222, 33333, -1));
    endtask

    task automatic test_thresholds();
        set_threshold(16'h0000);
        send_cell(make_cell(1, 2, 0, 64, 64, 64, 64, 0));
        send_cell(make_cell(9, 9, 1, 640, 64, 640, 64, 3000));
        set_threshold(16'hffff);
        send_cell(make_cell(1, 2, 65534, 64, 64, 64, 64, 0));
        send_cell(make_cell(4, 8, 65535, 64, 64, 64, 64, -3000));
        set_threshold(16'h1234);
        send_cell(make_cell(4, 8, 16'h1233, 64, 64, 64, 64, 0));
        send_cell(make_cell(4, 8, 16'h1234, 64, 64, 64, 64, 0));
    endtask

    task automatic test_random();
        logic [15:0] levels [4];
        levels = '{16'h8000, 16'h0000, 16'h4000, 16'hffff};
        for (int phase = 0; phase < 4; phase++)
        begin
            set_threshold(phase == 3 ? 16'(($urandom_range(65535))) : levels[phase]);
            quiet_sides = (phase == 2);
            for (int i = 0; i < 175; i++)
            begin
                send_cell(random_cell());
                if (i == 90)
                begin
                    wait_drained();
                end
            end
        end
        quiet_sides = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cell_valid = 1'b0;
        map_cell = '0;
        threshold_we = 1'b0;
        threshold_data = '0;
        quiet_sides = 1'b0;
        boxes_seen = 0;
        cells_sent = 0;
        mismatches = 0;
        cur_threshold = THRESHOLD_RESET;
        build_trig_tables();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_thresholds();
        test_random();
        wait_drained();
        $display("Sent %0d cells over several score thresholds, compared %0d boxes,",
                 cells_sent, boxes_seen);
        $display("with random stalls on both sides; %0d mismatches.", mismatches);
        if (mismatches == 0 && pending_boxes.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
